// ===== hw/rtl/som_pkg.sv =====
// som_pkg: shared constants, codes, tables and types for the self-organizing map engine
// depends on nothing; used by som_infl and som_bmu_search_and_train
package som_pkg;

    // map geometry and number formats
    localparam int MAX_SIDE    = 16;
    localparam int VEC_LEN     = 8;
    localparam int WEIGHT_BITS = 16;

    localparam int SIDE_W  = $clog2(MAX_SIDE);
    localparam int ELEM_W  = $clog2(VEC_LEN);
    localparam int NODE_W  = 2 * SIDE_W;
    localparam int NODES   = MAX_SIDE * MAX_SIDE;
    localparam int WADDR_W = NODE_W + ELEM_W;
    localparam int WDEPTH  = NODES * VEC_LEN;
    localparam int CNT_W   = SIDE_W + 1;
    localparam int DSQ_W   = 2 * SIDE_W + 1;
    localparam int SQ_W    = 2 * WEIGHT_BITS;
    localparam int ACC_W   = SQ_W + ELEM_W;
    localparam int DIST_W  = 37;
    localparam int STAT_W  = 48;

    // operation codes
    localparam logic [2:0] OP_WRITE  = 3'd0;
    localparam logic [2:0] OP_INIT   = 3'd1;
    localparam logic [2:0] OP_SEARCH = 3'd2;
    localparam logic [2:0] OP_TRAIN  = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    // register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_LRATE = 2'd2;
    localparam logic [1:0] REG_SCALE = 2'd3;

    localparam logic [15:0] MIN_INFLUENCE = 16'd7;

    // main sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SRCH,
        ST_SRCH_END,
        ST_TR_NODE,
        ST_TR_INF,
        ST_TR_ELEM,
        ST_TR_DRAIN,
        ST_HIT_RD,
        ST_HIT_WR,
        ST_DONE,
        ST_INIT_CALC,
        ST_INIT_WR
    } state_t;

    // influence unit states
    typedef enum logic [2:0] {
        IF_IDLE,
        IF_MUL,
        IF_STEP,
        IF_GAIN,
        IF_DONE
    } infl_state_t;

    typedef struct packed {
        logic             start;
        logic [DSQ_W-1:0] dsq;
    } infl_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] inf;
        logic [15:0] gain;
    } infl_rsp_t;

    // exp(-2^(k-12)) in Q0.16
    function automatic logic [15:0] exp_tab(input logic [3:0] k);
        logic [15:0] v;
        begin
            case (k)
                4'd0:    v = 16'd65520;
                4'd1:    v = 16'd65504;
                4'd2:    v = 16'd65472;
                4'd3:    v = 16'd65408;
                4'd4:    v = 16'd65280;
                4'd5:    v = 16'd65026;
                4'd6:    v = 16'd64520;
                4'd7:    v = 16'd63520;
                4'd8:    v = 16'd61565;
                4'd9:    v = 16'd57835;
                4'd10:   v = 16'd51039;
                4'd11:   v = 16'd39750;
                4'd12:   v = 16'd24109;
                4'd13:   v = 16'd8869;
                4'd14:   v = 16'd1200;
                default: v = 16'd22;
            endcase
            return v;
        end
    endfunction

    // ceil(2^24 / d); zero for a side of one
    function automatic logic [24:0] recip(input logic [3:0] d);
        logic [24:0] v;
        begin
            case (d)
                4'd1:    v = 25'd16777216;
                4'd2:    v = 25'd8388608;
                4'd3:    v = 25'd5592406;
                4'd4:    v = 25'd4194304;
                4'd5:    v = 25'd3355444;
                4'd6:    v = 25'd2796203;
                4'd7:    v = 25'd2396746;
                4'd8:    v = 25'd2097152;
                4'd9:    v = 25'd1864136;
                4'd10:   v = 25'd1677722;
                4'd11:   v = 25'd1525202;
                4'd12:   v = 25'd1398102;
                4'd13:   v = 25'd1290556;
                4'd14:   v = 25'd1198373;
                4'd15:   v = 25'd1118482;
                default: v = 25'd0;
            endcase
            return v;
        end
    endfunction

    // clamp a side register write to 1..MAX_SIDE
    function automatic logic [CNT_W-1:0] clamp_side(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        begin
            if (v == '0)
                r = CNT_W'(1);
            else if (v > CNT_W'(MAX_SIDE))
                r = CNT_W'(MAX_SIDE);
            else
                r = v;
            return r;
        end
    endfunction

    // saturate an updated weight to the signed weight range
    function automatic logic [WEIGHT_BITS-1:0] sat_weight(input logic signed [WEIGHT_BITS+1:0] v);
        logic [WEIGHT_BITS-1:0] r;
        begin
            if (v[WEIGHT_BITS+1:WEIGHT_BITS-1] == 3'b000 || v[WEIGHT_BITS+1:WEIGHT_BITS-1] == 3'b111)
                r = v[WEIGHT_BITS-1:0];
            else if (v[WEIGHT_BITS+1])
                r = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
            else
                r = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/som_infl.sv =====
// som_infl: iterative gaussian neighborhood influence and learning gain
// depends on som_pkg (exp table, request and response types)
module som_infl (
    input  logic                clk,
    input  logic                rst_n,
    input  som_pkg::infl_req_t  req,
    input  logic [15:0]         learn_rate,
    input  logic [15:0]         neighbor_scale,
    output som_pkg::infl_rsp_t  rsp
);

    som_pkg::infl_state_t state_reg, state_next;

    logic [24:0] x_reg;
    logic [3:0]  k_reg;
    logic [16:0] acc_reg;
    logic [15:0] inf_reg;
    logic [15:0] gain_reg;

    logic [32:0] step_prod;
    logic [15:0] inf_sat;
    logic [31:0] gain_prod;
    logic        x_over;

    // one table factor per set bit of x
    assign step_prod = 33'(acc_reg) * 33'(som_pkg::exp_tab(k_reg));
    assign inf_sat   = acc_reg[16] ? 16'hFFFF : acc_reg[15:0];
    assign gain_prod = 32'(learn_rate) * 32'(inf_sat);
    assign x_over    = (x_reg[24:16] != '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            som_pkg::IF_IDLE: if (req.start) state_next = som_pkg::IF_MUL;
            som_pkg::IF_MUL:  state_next = x_over ? som_pkg::IF_GAIN : som_pkg::IF_STEP;
            som_pkg::IF_STEP: if (k_reg == 4'd15) state_next = som_pkg::IF_GAIN;
            som_pkg::IF_GAIN: state_next = som_pkg::IF_DONE;
            som_pkg::IF_DONE: state_next = som_pkg::IF_IDLE;
            default:          state_next = som_pkg::IF_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        rsp.done = (state_reg == som_pkg::IF_DONE);
        rsp.inf  = inf_reg;
        rsp.gain = gain_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= som_pkg::IF_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            som_pkg::IF_IDLE:
            begin
                x_reg   <= 25'(req.dsq) * 25'(neighbor_scale);
                acc_reg <= 17'h10000;
                k_reg   <= 4'd0;
            end
            som_pkg::IF_MUL:
            begin
                if (x_over)
                    acc_reg <= '0;
            end
            som_pkg::IF_STEP:
            begin
                if (x_reg[k_reg])
                    acc_reg <= step_prod[32:16];
                k_reg <= k_reg + 4'd1;
            end
            som_pkg::IF_GAIN:
            begin
                inf_reg  <= inf_sat;
                gain_reg <= gain_prod[31:16];
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ===== hw/rtl/som_bmu_search_and_train.sv =====
// som_bmu_search_and_train: self-organizing map engine, best-match search and training
// depends on som_pkg and som_infl
//
//  channel   signals                                          timing
//  command   start, busy, op, node_row, node_col, element,    beat taken when start & !busy
//            value, last
//  result    result_valid, bmu_row, bmu_col, bmu_index,       one-cycle strobe, no back-pressure
//            best_dist_sq, hit_total, peak_activation,
//            weight_out
//  config    cfg_we, cfg_index, cfg_wdata                     write on any edge with cfg_we
//
// weight write and sample element without last: taken while idle, busy stays low
// node read: memories read on the beat, result registered from the read state
// search: one weight memory read per cycle across the sweep
// train: the search sweep, then per node an influence calculation (shortened for nodes out of reach),
//   an element update for nodes that update, then the hit count and the result
// grid init: per node a ramp calculation, then a write of each element; reset clears the statistics valid bits at once
module som_bmu_search_and_train (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  op,
    input  logic [3:0]  node_row,
    input  logic [3:0]  node_col,
    input  logic [2:0]  element,
    input  logic signed [15:0] value,
    input  logic        last,
    output logic        result_valid,
    output logic [3:0]  bmu_row,
    output logic [3:0]  bmu_col,
    output logic [7:0]  bmu_index,
    output logic [36:0] best_dist_sq,
    output logic [31:0] hit_total,
    output logic [15:0] peak_activation,
    output logic signed [15:0] weight_out,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    localparam int SW = som_pkg::SIDE_W;
    localparam int EW = som_pkg::ELEM_W;
    localparam int WB = som_pkg::WEIGHT_BITS;

    som_pkg::state_t state_reg, state_next;

    // configuration
    logic [som_pkg::CNT_W-1:0] rows_reg, cols_reg;
    logic [15:0]               lr_reg, ns_reg;

    // sweep counters and command
    logic [2:0]    op_reg;
    logic [SW-1:0] r_reg, c_reg;
    logic [EW-1:0] e_reg;
    logic [WB-1:0] sample_buf [som_pkg::VEC_LEN];

    // winner
    logic [SW-1:0]             br_reg, bc_reg;
    logic [som_pkg::ACC_W-1:0] best_reg, acc_reg;
    logic                      found_reg;

    // memories
    logic [WB-1:0]              wt_mem [som_pkg::WDEPTH];
    logic [WB-1:0]              wt_rdata_reg;
    logic [som_pkg::STAT_W-1:0] stat_mem [som_pkg::NODES];
    logic [som_pkg::STAT_W-1:0] stat_rdata_reg;
    logic                       stat_rvld_reg;
    logic [som_pkg::NODES-1:0]  stat_vld_reg;

    // pipeline
    logic                      p1_vld_reg, p1_train_reg, p1_last_reg;
    logic [som_pkg::NODE_W-1:0] p1_node_reg;
    logic [EW-1:0]             p1_e_reg;
    logic                      sq_vld_reg, sq_last_reg;
    logic [som_pkg::NODE_W-1:0] sq_node_reg;
    logic [som_pkg::SQ_W-1:0]  sq_reg;
    logic                      up_vld_reg;
    logic [som_pkg::WADDR_W-1:0] up_addr_reg;
    logic signed [WB-1:0]      up_w_reg;
    logic signed [2*WB+1:0]    up_p_reg;

    // grid init values
    logic [WB-1:0] xf_reg, yf_reg;

    // control
    logic                        accept, smp_we, cnt_clr, srch_clr, elem_step, node_step;
    logic                        rd_issue, rd_train;
    logic                        wt_we;
    logic [som_pkg::WADDR_W-1:0] wt_waddr, wt_raddr;
    logic [WB-1:0]               wt_wdata;
    logic                        stat_re, stat_we, stat_clr;
    logic [som_pkg::NODE_W-1:0]  stat_raddr, stat_waddr;
    logic [som_pkg::STAT_W-1:0]  stat_wdata;
    logic                        xy_load, res_srch, res_read;

    // derived values
    logic                        elem_last, col_last, node_last, drained;
    logic [15:0]                 stat_act;
    logic [31:0]                 stat_hits, hits_inc;
    logic [15:0]                 act_max;
    logic signed [WB:0]          diff;
    logic signed [2*WB+1:0]      sq_full, p_full;
    logic [som_pkg::ACC_W-1:0]   acc_sum;
    logic signed [WB+1:0]        upd_sum;
    logic signed [SW:0]          dr, dc;
    logic signed [2*SW+1:0]      dr_sq, dc_sq;
    logic [28:0]                 xprod, yprod;
    logic [8:0]                  idx_full;
    som_pkg::infl_req_t          infl_req;
    som_pkg::infl_rsp_t          infl_rsp;

    assign accept    = start && !busy;
    assign busy      = (state_reg != som_pkg::ST_IDLE);
    assign elem_last = (e_reg == EW'(som_pkg::VEC_LEN - 1));
    assign col_last  = ({1'b0, c_reg} == cols_reg - som_pkg::CNT_W'(1));
    assign node_last = col_last && ({1'b0, r_reg} == rows_reg - som_pkg::CNT_W'(1));
    assign drained   = !p1_vld_reg && !sq_vld_reg && !up_vld_reg;

    assign stat_act  = stat_rvld_reg ? stat_rdata_reg[15:0] : 16'd0;
    assign stat_hits = stat_rvld_reg ? stat_rdata_reg[47:16] : 32'd0;
    assign hits_inc  = (stat_hits == 32'hFFFF_FFFF) ? stat_hits : stat_hits + 32'd1;
    assign act_max   = (infl_rsp.inf > stat_act) ? infl_rsp.inf : stat_act;

    // element arithmetic on the registered weight
    assign diff    = $signed({sample_buf[p1_e_reg][WB-1], sample_buf[p1_e_reg]})
                   - $signed({wt_rdata_reg[WB-1], wt_rdata_reg});
    assign sq_full = diff * diff;
    assign p_full  = $signed({1'b0, infl_rsp.gain}) * diff;
    assign acc_sum = acc_reg + som_pkg::ACC_W'(sq_reg);
    assign upd_sum = $signed({{2{up_w_reg[WB-1]}}, up_w_reg}) + $signed(up_p_reg[2*WB+1:16]);

    // grid distance to the winner
    assign dr    = $signed({1'b0, r_reg}) - $signed({1'b0, br_reg});
    assign dc    = $signed({1'b0, c_reg}) - $signed({1'b0, bc_reg});
    assign dr_sq = dr * dr;
    assign dc_sq = dc * dc;
    assign infl_req.start = (state_reg == som_pkg::ST_TR_NODE);
    assign infl_req.dsq   = som_pkg::DSQ_W'(dr_sq) + som_pkg::DSQ_W'(dc_sq);

    // ramp values by reciprocal multiply
    assign xprod = 29'(c_reg) * 29'(som_pkg::recip(4'(cols_reg - som_pkg::CNT_W'(1))));
    assign yprod = 29'(r_reg) * 29'(som_pkg::recip(4'(rows_reg - som_pkg::CNT_W'(1))));

    assign idx_full = 9'(br_reg) * 9'(cols_reg) + 9'(bc_reg);

    som_infl u_infl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (infl_req),
        .learn_rate     (lr_reg),
        .neighbor_scale (ns_reg),
        .rsp            (infl_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            som_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        som_pkg::OP_INIT:   state_next = som_pkg::ST_INIT_CALC;
                        som_pkg::OP_READ:   state_next = som_pkg::ST_READ;
                        som_pkg::OP_SEARCH,
                        som_pkg::OP_TRAIN:  if (last) state_next = som_pkg::ST_SRCH;
                        default:            state_next = som_pkg::ST_IDLE;
                    endcase
                end
            end
            som_pkg::ST_READ:      state_next = som_pkg::ST_IDLE;
            som_pkg::ST_SRCH:
            begin
                if (elem_last && node_last)
                    state_next = som_pkg::ST_SRCH_END;
            end
            som_pkg::ST_SRCH_END:
            begin
                if (drained)
                    state_next = (op_reg == som_pkg::OP_TRAIN) ? som_pkg::ST_TR_NODE
                                                               : som_pkg::ST_DONE;
            end
            som_pkg::ST_TR_NODE:   state_next = som_pkg::ST_TR_INF;
            som_pkg::ST_TR_INF:
            begin
                if (infl_rsp.done)
                begin
                    if (infl_rsp.inf >= som_pkg::MIN_INFLUENCE)
                        state_next = som_pkg::ST_TR_ELEM;
                    else
                        state_next = node_last ? som_pkg::ST_HIT_RD : som_pkg::ST_TR_NODE;
                end
            end
            som_pkg::ST_TR_ELEM:   if (elem_last) state_next = som_pkg::ST_TR_DRAIN;
            som_pkg::ST_TR_DRAIN:
            begin
                if (drained)
                    state_next = node_last ? som_pkg::ST_HIT_RD : som_pkg::ST_TR_NODE;
            end
            som_pkg::ST_HIT_RD:    state_next = som_pkg::ST_HIT_WR;
            som_pkg::ST_HIT_WR:    state_next = som_pkg::ST_DONE;
            som_pkg::ST_DONE:      state_next = som_pkg::ST_IDLE;
            som_pkg::ST_INIT_CALC: state_next = som_pkg::ST_INIT_WR;
            som_pkg::ST_INIT_WR:
            begin
                if (elem_last)
                    state_next = node_last ? som_pkg::ST_IDLE : som_pkg::ST_INIT_CALC;
            end
            default:               state_next = som_pkg::ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        smp_we     = 1'b0;
        cnt_clr    = 1'b0;
        srch_clr   = 1'b0;
        elem_step  = 1'b0;
        node_step  = 1'b0;
        rd_issue   = 1'b0;
        rd_train   = 1'b0;
        wt_we      = 1'b0;
        wt_waddr   = {r_reg, c_reg, e_reg};
        wt_wdata   = e_reg[0] ? yf_reg : xf_reg;
        wt_raddr   = {r_reg, c_reg, e_reg};
        stat_re    = 1'b0;
        stat_raddr = {r_reg, c_reg};
        stat_we    = 1'b0;
        stat_clr   = 1'b0;
        stat_waddr = {r_reg, c_reg};
        stat_wdata = {stat_hits, act_max};
        xy_load    = 1'b0;
        res_srch   = 1'b0;
        res_read   = 1'b0;
        case (state_reg)
            som_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        som_pkg::OP_WRITE:
                        begin
                            wt_we    = 1'b1;
                            wt_waddr = {node_row, node_col, element};
                            wt_wdata = value;
                        end
                        som_pkg::OP_INIT:
                        begin
                            cnt_clr = 1'b1;
                        end
                        som_pkg::OP_SEARCH,
                        som_pkg::OP_TRAIN:
                        begin
                            smp_we   = 1'b1;
                            cnt_clr  = 1'b1;
                            srch_clr = last;
                        end
                        som_pkg::OP_READ:
                        begin
                            wt_raddr   = {node_row, node_col, element};
                            stat_re    = 1'b1;
                            stat_raddr = {node_row, node_col};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            som_pkg::ST_READ:      res_read = 1'b1;
            som_pkg::ST_SRCH:
            begin
                rd_issue  = 1'b1;
                elem_step = 1'b1;
                node_step = elem_last;
            end
            som_pkg::ST_SRCH_END:  cnt_clr = 1'b1;
            som_pkg::ST_TR_NODE:   stat_re = 1'b1;
            som_pkg::ST_TR_INF:
            begin
                if (infl_rsp.done)
                begin
                    if (infl_rsp.inf >= som_pkg::MIN_INFLUENCE)
                        stat_we = 1'b1;
                    else
                        node_step = 1'b1;
                end
            end
            som_pkg::ST_TR_ELEM:
            begin
                rd_issue  = 1'b1;
                rd_train  = 1'b1;
                elem_step = 1'b1;
            end
            som_pkg::ST_TR_DRAIN:  node_step = drained;
            som_pkg::ST_HIT_RD:
            begin
                stat_re    = 1'b1;
                stat_raddr = {br_reg, bc_reg};
            end
            som_pkg::ST_HIT_WR:
            begin
                stat_we    = 1'b1;
                stat_waddr = {br_reg, bc_reg};
                stat_wdata = {hits_inc, stat_act};
            end
            som_pkg::ST_DONE:      res_srch = 1'b1;
            som_pkg::ST_INIT_CALC:
            begin
                stat_clr = 1'b1;
                xy_load  = 1'b1;
            end
            som_pkg::ST_INIT_WR:
            begin
                wt_we     = 1'b1;
                elem_step = 1'b1;
                node_step = elem_last;
            end
            default:
            begin
            end
        endcase
        // write-back of the update stage
        if (up_vld_reg)
        begin
            wt_we    = 1'b1;
            wt_waddr = up_addr_reg;
            wt_wdata = som_pkg::sat_weight(upd_sum);
        end
    end

    // state, configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= som_pkg::ST_IDLE;
            rows_reg     <= som_pkg::CNT_W'(som_pkg::MAX_SIDE);
            cols_reg     <= som_pkg::CNT_W'(som_pkg::MAX_SIDE);
            lr_reg       <= 16'd32768;
            ns_reg       <= 16'd512;
            p1_vld_reg   <= 1'b0;
            sq_vld_reg   <= 1'b0;
            up_vld_reg   <= 1'b0;
            result_valid <= 1'b0;
            stat_vld_reg <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            p1_vld_reg   <= rd_issue;
            sq_vld_reg   <= p1_vld_reg && !p1_train_reg;
            up_vld_reg   <= p1_vld_reg && p1_train_reg;
            result_valid <= res_srch || res_read;
            if (cfg_we)
            begin
                case (cfg_index)
                    som_pkg::REG_ROWS:  rows_reg <= som_pkg::clamp_side(cfg_wdata[4:0]);
                    som_pkg::REG_COLS:  cols_reg <= som_pkg::clamp_side(cfg_wdata[4:0]);
                    som_pkg::REG_LRATE: lr_reg   <= cfg_wdata;
                    som_pkg::REG_SCALE: ns_reg   <= cfg_wdata;
                    default:            ns_reg   <= ns_reg;
                endcase
            end
            if (stat_we)
                stat_vld_reg[stat_waddr] <= 1'b1;
            else if (stat_clr)
                stat_vld_reg[stat_waddr] <= 1'b0;
            if (srch_clr)
                found_reg <= 1'b0;
            else if (sq_vld_reg && sq_last_reg)
                found_reg <= 1'b1;
        end
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (wt_we)
            wt_mem[wt_waddr] <= wt_wdata;
        wt_rdata_reg <= wt_mem[wt_raddr];
    end

    // node statistics memory: hit count and peak activation
    always_ff @(posedge clk)
    begin
        if (stat_we)
            stat_mem[stat_waddr] <= stat_wdata;
        if (stat_re)
        begin
            stat_rdata_reg <= stat_mem[stat_raddr];
            stat_rvld_reg  <= stat_vld_reg[stat_raddr];
        end
    end

    // sweep counters, sample buffer and datapath
    always_ff @(posedge clk)
    begin
        if (accept)
            op_reg <= op;
        if (smp_we)
            sample_buf[element] <= value;
        if (cnt_clr)
        begin
            r_reg <= '0;
            c_reg <= '0;
            e_reg <= '0;
        end
        else
        begin
            if (elem_step)
                e_reg <= elem_last ? '0 : e_reg + EW'(1);
            if (node_step)
            begin
                c_reg <= col_last ? '0 : c_reg + SW'(1);
                if (col_last)
                    r_reg <= r_reg + SW'(1);
            end
        end

        // read stage tags
        p1_train_reg <= rd_train;
        p1_last_reg  <= elem_last;
        p1_node_reg  <= {r_reg, c_reg};
        p1_e_reg     <= e_reg;

        // square or product stage
        sq_reg      <= sq_full[som_pkg::SQ_W-1:0];
        sq_last_reg <= p1_last_reg;
        sq_node_reg <= p1_node_reg;
        up_p_reg    <= p_full;
        up_w_reg    <= wt_rdata_reg;
        up_addr_reg <= {p1_node_reg, p1_e_reg};

        // accumulate distance and keep the first strict minimum
        if (srch_clr)
            acc_reg <= '0;
        else if (sq_vld_reg)
        begin
            if (sq_last_reg)
            begin
                acc_reg <= '0;
                if (!found_reg || acc_sum < best_reg)
                begin
                    best_reg <= acc_sum;
                    br_reg   <= sq_node_reg[2*SW-1:SW];
                    bc_reg   <= sq_node_reg[SW-1:0];
                end
            end
            else
                acc_reg <= acc_sum;
        end

        if (xy_load)
        begin
            xf_reg <= WB'(xprod >> 12);
            yf_reg <= WB'(yprod >> 12);
        end

        // result beat
        if (res_srch)
        begin
            bmu_row         <= br_reg;
            bmu_col         <= bc_reg;
            bmu_index       <= idx_full[7:0];
            best_dist_sq    <= som_pkg::DIST_W'(best_reg);
            hit_total       <= '0;
            peak_activation <= '0;
            weight_out      <= '0;
        end
        else if (res_read)
        begin
            bmu_row         <= '0;
            bmu_col         <= '0;
            bmu_index       <= '0;
            best_dist_sq    <= '0;
            hit_total       <= stat_hits;
            peak_activation <= stat_act;
            weight_out      <= wt_rdata_reg;
        end
    end

    // result strobe lasts one cycle
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held longer than one cycle");

    // no weight write lands during the distance sweep
    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == som_pkg::ST_SRCH) |-> !wt_we)
        else $error("weight write during search sweep");

    // a final sample element starts a sweep
    a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (op == som_pkg::OP_SEARCH || op == som_pkg::OP_TRAIN) && last)
        |=> busy)
        else $error("final element did not start a search");

    // a new node only starts after the previous update drained
    a_node_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == som_pkg::ST_TR_NODE) |-> (!up_vld_reg && !p1_vld_reg))
        else $error("node update overlaps previous node");

endmodule

// ===== test/tb.sv =====
// tb: self-checking bench for som_bmu_search_and_train, drives command beats and register writes
// depends on som_pkg and the som_bmu_search_and_train rtl; keeps its own map model for checking
`timescale 1ns / 100ps

module tb;

    localparam logic [2:0] OP_NONE = 3'd7;
    localparam longint DIST_SAT = (64'd1 << 37) - 1;
    localparam int LIMIT = 3000000;

    typedef struct {
        logic [2:0]         op;
        logic [3:0]         row;
        logic [3:0]         col;
        logic [2:0]         elem;
        logic signed [15:0] val;
        logic               lst;
    } cmd_t;

    typedef struct {
        logic [3:0]         brow;
        logic [3:0]         bcol;
        logic [7:0]         bidx;
        logic [36:0]        dsq;
        logic [31:0]        hits;
        logic [15:0]        peak;
        logic signed [15:0] wout;
    } res_t;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t r;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] op = '0;
    logic [3:0] node_row = '0;
    logic [3:0] node_col = '0;
    logic [2:0] element = '0;
    logic signed [15:0] value = '0;
    logic last = 1'b0;
    logic result_valid;
    logic [3:0] bmu_row;
    logic [3:0] bmu_col;
    logic [7:0] bmu_index;
    logic [36:0] best_dist_sq;
    logic [31:0] hit_total;
    logic [15:0] peak_activation;
    logic signed [15:0] weight_out;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    som_bmu_search_and_train dut (.*);

    // map model state
    logic signed [15:0] m_weight [som_pkg::NODES*som_pkg::VEC_LEN];
    logic [15:0]        m_peak [som_pkg::NODES];
    logic [31:0]        m_hits [som_pkg::NODES];
    logic signed [15:0] m_sample [som_pkg::VEC_LEN];
    int unsigned        m_rows, m_cols, m_lrate, m_scale;

    res_t pending_results[$];
    int   errors = 0;
    int   idle_pct = 23;
    int   sent = 0;
    longint cycles = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int unsigned clamp_rc(input logic [15:0] v);
        int unsigned x;
        x = v[4:0];
        if (x < 1) x = 1;
        if (x > som_pkg::MAX_SIDE) x = som_pkg::MAX_SIDE;
        return x;
    endfunction

    function automatic logic [15:0] exp_q16(input int k);
        logic [15:0] t [16] = '{16'd65520, 16'd65504, 16'd65472, 16'd65408, 16'd65280,
                                16'd65026, 16'd64520, 16'd63520, 16'd61565, 16'd57835,
                                16'd51039, 16'd39750, 16'd24109, 16'd8869, 16'd1200, 16'd22};
        return t[k];
    endfunction

    function automatic longint influence(input longint gdsq);
        longint x;
        longint acc;
        x = gdsq * m_scale;
        acc = 65536;
        if (x > 65535) return 0;
        for (int k = 0; k < 16; k++)
            if (x[k]) acc = (acc * exp_q16(k)) >>> 16;
        return acc > 65535 ? 65535 : acc;
    endfunction

    function automatic longint sat16(input longint v);
        return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
    endfunction

    // grid init ramp over the active nodes
    task automatic ramp_grid();
        longint xf, yf;
        for (int r = 0; r < m_rows; r++)
            for (int c = 0; c < m_cols; c++) begin
                xf = m_cols > 1 ? (c * 4096) / (m_cols - 1) : 0;
                yf = m_rows > 1 ? (r * 4096) / (m_rows - 1) : 0;
                for (int e = 0; e < som_pkg::VEC_LEN; e++)
                    m_weight[(r*som_pkg::MAX_SIDE+c)*som_pkg::VEC_LEN+e] =
                        16'(sat16(e[0] ? yf : xf));
                m_peak[r*som_pkg::MAX_SIDE+c] = '0;
                m_hits[r*som_pkg::MAX_SIDE+c] = '0;
            end
    endtask

    // neighbourhood update around the winner
    task automatic train_map(input int br, input int bc);
        longint inf, g, p, w;
        int n;
        for (int r = 0; r < m_rows; r++)
            for (int c = 0; c < m_cols; c++) begin
                inf = influence((r-br)*(r-br) + (c-bc)*(c-bc));
                n = r*som_pkg::MAX_SIDE + c;
                if (inf < 7) continue;
                g = (longint'(m_lrate) * inf) >>> 16;
                for (int e = 0; e < som_pkg::VEC_LEN; e++) begin
                    w = m_weight[n*som_pkg::VEC_LEN+e];
                    p = g * (longint'(m_sample[e]) - w);
                    m_weight[n*som_pkg::VEC_LEN+e] = 16'(sat16(w + (p >>> 16)));
                end
                if (inf > m_peak[n]) m_peak[n] = 16'(inf);
            end
        n = br*som_pkg::MAX_SIDE + bc;
        if (m_hits[n] != 32'hFFFF_FFFF) m_hits[n] = m_hits[n] + 1;
    endtask

    // expected result of one accepted beat, if any
    task automatic model_step(input cmd_t c, output bit got, output res_t r);
        longint best, d, sum;
        int br, bc, n;
        bit found;
        got = 0;
        r = '{default: '0};
        case (c.op)
            som_pkg::OP_WRITE:
                m_weight[(c.row*som_pkg::MAX_SIDE+c.col)*som_pkg::VEC_LEN+c.elem] = c.val;
            som_pkg::OP_INIT:  ramp_grid();
            som_pkg::OP_SEARCH, som_pkg::OP_TRAIN: begin
                m_sample[c.elem] = c.val;
                if (c.lst) begin
                    found = 0; best = 0; br = 0; bc = 0;
                    for (int rr = 0; rr < m_rows; rr++)
                        for (int cc = 0; cc < m_cols; cc++) begin
                            sum = 0;
                            for (int e = 0; e < som_pkg::VEC_LEN; e++) begin
                                d = longint'(m_sample[e])
                                  - m_weight[(rr*som_pkg::MAX_SIDE+cc)*som_pkg::VEC_LEN+e];
                                sum = sum + d*d;
                                if (sum > DIST_SAT) sum = DIST_SAT;
                            end
                            if (!found || sum < best) begin
                                found = 1; best = sum; br = rr; bc = cc;
                            end
                        end
                    if (c.op == som_pkg::OP_TRAIN) train_map(br, bc);
                    got = 1;
                    r.brow = 4'(br);
                    r.bcol = 4'(bc);
                    r.bidx = 8'(br*m_cols + bc);
                    r.dsq = 37'(best);
                end
            end
            som_pkg::OP_READ: begin
                n = c.row*som_pkg::MAX_SIDE + c.col;
                got = 1;
                r.hits = m_hits[n];
                r.peak = m_peak[n];
                r.wout = m_weight[n*som_pkg::VEC_LEN+c.elem];
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input longint e, input longint a);
        if (e != a) begin
            errors++;
            $display("%0t %s expected %0d got %0d", $time, name, e, a);
        end
    endtask

    // result beats against the oldest expectation
    always @(posedge clk) begin
        res_t x;
        if (rst_n && result_valid) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t unexpected result beat, expected none got bmu_index %0d",
                         $time, bmu_index);
            end else begin
                x = pending_results.pop_front();
                check_field("bmu_row", x.brow, bmu_row);
                check_field("bmu_col", x.bcol, bmu_col);
                check_field("bmu_index", x.bidx, bmu_index);
                check_field("best_dist_sq", x.dsq, best_dist_sq);
                check_field("hit_total", x.hits, hit_total);
                check_field("peak_activation", x.peak, peak_activation);
                check_field("weight_out", x.wout, weight_out);
            end
        end
    end

    // one command beat, with an optional sender gap ahead of it
    task automatic issue(input cmd_t c, input bit typed, input res_t tr);
        bit got;
        res_t r;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        op <= c.op;
        node_row <= c.row;
        node_col <= c.col;
        element <= c.elem;
        value <= c.val;
        last <= c.lst;
        do @(posedge clk); while (busy);
        model_step(c, got, r);
        if (got) pending_results.push_back(typed ? tr : r);
        sent++;
    endtask

    // drain the block before touching the registers
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        do @(posedge clk); while (busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic set_regs(input logic [15:0] rows, input logic [15:0] cols,
                            input logic [15:0] lr, input logic [15:0] sc);
        logic [15:0] v [4];
        v = '{rows, cols, lr, sc};
        for (int i = 0; i < 4; i++) begin
            cfg_we <= 1'b1;
            cfg_index <= 2'(i);
            cfg_wdata <= v[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        m_rows = clamp_rc(rows);
        m_cols = clamp_rc(cols);
        m_lrate = lr;
        m_scale = sc;
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($signed($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic cmd_t mk(input logic [2:0] o, input int r, input int c, input int e,
                                input logic signed [15:0] v, input bit l);
        cmd_t x;
        x.op = o; x.row = 4'(r); x.col = 4'(c); x.elem = 3'(e); x.val = v; x.lst = l;
        return x;
    endfunction

    function automatic res_t rd(input longint h, input longint p, input longint w);
        res_t x;
        x = '{default: '0};
        x.hits = 32'(h); x.peak = 16'(p); x.wout = 16'(w);
        return x;
    endfunction

    // random mix: mostly whole samples, some noise
    task automatic random_items(input int n);
        int stop;
        logic [2:0] o;
        res_t none;
        none = '{default: '0};
        stop = sent + n;
        while (sent < stop) begin
            if (sent > 100) idle_pct = 0;
            else if (sent > 60) idle_pct = 54;
            else idle_pct = 23;
            if ($urandom_range(0, 99) < 70) begin
                o = $urandom_range(0, 1) ? som_pkg::OP_TRAIN : som_pkg::OP_SEARCH;
                for (int e = 0; e < som_pkg::VEC_LEN; e++)
                    issue(mk(o, $urandom_range(0, 15), $urandom_range(0, 15), e,
                             rand_value(), e == som_pkg::VEC_LEN-1), 0, none);
            end else begin
                case ($urandom_range(0, 5))
                    0: issue(mk(som_pkg::OP_WRITE, $urandom_range(0, 15),
                                $urandom_range(0, 15), $urandom_range(0, 7), rand_value(),
                                $urandom_range(0, 1)), 0, none);
                    1, 2: issue(mk(som_pkg::OP_READ, $urandom_range(0, 15),
                                   $urandom_range(0, 15), $urandom_range(0, 7), rand_value(),
                                   $urandom_range(0, 1)), 0, none);
                    3: issue(mk(3'($urandom_range(5, 7)), $urandom_range(0, 15),
                                $urandom_range(0, 15), $urandom_range(0, 7), rand_value(),
                                $urandom_range(0, 1)), 0, none);
                    4: issue(mk(som_pkg::OP_INIT, 0, 0, 0, rand_value(), 0), 0, none);
                    default: issue(mk($urandom_range(0, 1) ? som_pkg::OP_TRAIN
                                                           : som_pkg::OP_SEARCH,
                                      $urandom_range(0, 15), $urandom_range(0, 15),
                                      $urandom_range(0, 7), rand_value(), 1), 0, none);
                endcase
            end
        end
    endtask

    row_t plan [$];

    initial begin
        res_t none;
        none = '{default: '0};
        foreach (m_weight[i]) m_weight[i] = '0;
        foreach (m_peak[i]) m_peak[i] = '0;
        foreach (m_hits[i]) m_hits[i] = '0;
        foreach (m_sample[i]) m_sample[i] = '0;
        m_rows = 16; m_cols = 16; m_lrate = 32768; m_scale = 512;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed table on the reset grid size
        plan.push_back('{mk(som_pkg::OP_INIT, 0, 0, 0, 0, 0), 0, none});
        plan.push_back('{mk(som_pkg::OP_READ, 0, 0, 0, 0, 0), 1, rd(0, 0, 0)});
        plan.push_back('{mk(som_pkg::OP_READ, 15, 15, 1, 0, 1), 1, rd(0, 0, 4096)});
        plan.push_back('{mk(som_pkg::OP_READ, 15, 0, 0, 0, 0), 1, rd(0, 0, 0)});
        plan.push_back('{mk(som_pkg::OP_WRITE, 3, 5, 2, 16'sh8000, 0), 0, none});
        plan.push_back('{mk(som_pkg::OP_WRITE, 3, 5, 3, 16'sh7FFF, 1), 0, none});
        plan.push_back('{mk(som_pkg::OP_READ, 3, 5, 2, 0, 0), 1, rd(0, 0, -32768)});
        plan.push_back('{mk(som_pkg::OP_READ, 3, 5, 3, 0, 0), 1, rd(0, 0, 32767)});
        for (int e = 0; e < som_pkg::VEC_LEN; e++)
            plan.push_back('{mk(som_pkg::OP_SEARCH, 0, 0, e, e[0] ? 16'sh7FFF : 16'sh8000,
                                e == som_pkg::VEC_LEN-1), 0, none});
        plan.push_back('{mk(som_pkg::OP_TRAIN, 9, 9, 2, 16'sh8000, 1), 0, none});
        plan.push_back('{mk(som_pkg::OP_READ, 3, 5, 2, 0, 0), 0, none});
        plan.push_back('{mk(OP_NONE, 15, 15, 7, 16'sh7FFF, 1), 0, none});
        plan.push_back('{mk(som_pkg::OP_TRAIN, 0, 0, 0, 16'sh0000, 1), 0, none});
        plan.push_back('{mk(som_pkg::OP_READ, 0, 0, 7, 0, 1), 0, none});
        plan.push_back('{mk(som_pkg::OP_SEARCH, 15, 15, 5, 16'sh0800, 0), 0, none});
        foreach (plan[i]) issue(plan[i].c, plan[i].typed, plan[i].r);

        // register settings, extremes first
        settle();
        set_regs(16'd0, 16'd31, 16'hFFFF, 16'h0000);
        issue(mk(som_pkg::OP_INIT, 0, 0, 0, 0, 0), 0, none);
        random_items(25);
        settle();
        set_regs(16'd16, 16'd1, 16'h0000, 16'hFFFF);
        issue(mk(som_pkg::OP_INIT, 0, 0, 0, 0, 0), 0, none);
        random_items(20);
        settle();
        set_regs(16'hFFE3, 16'd5, 16'd40000, 16'd4096);
        random_items(25);
        settle();
        set_regs(16'd4, 16'd4, 16'hFFFF, 16'd300);
        issue(mk(som_pkg::OP_INIT, 0, 0, 0, 0, 0), 0, none);
        random_items(30);
        settle();
        set_regs(16'd16, 16'd16, 16'd32768, 16'd512);
        random_items(12);

        // wait for the last results, then for the block to go quiet
        settle();
        if (errors == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/som_pkg.sv
hw/rtl/som_infl.sv
hw/rtl/som_bmu_search_and_train.sv
test/tb.sv
